// File: sv/pcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcm_pkg;
   localparam int COEF_W = 40;
   localparam int NUM_COEFS = 8;
   localparam int PIX_W = 10;
   localparam int IMAGE_COLS = 640;
   localparam int IMAGE_ROWS = 480;
   localparam int SUM_W = 52;              // 40x11 product plus carries
   localparam int MAG_W = SUM_W - 1;       // magnitude of a sum
   localparam int Q_W = PIX_W;             // quotient bits kept
   localparam int IDX_W = 3;
   localparam logic [SUM_W-1:0] Q_ONE = SUM_W'(64'd16777216);
   localparam logic [COEF_W-1:0] ONE_COEF = COEF_W'(64'd16777216);
   localparam logic [IDX_W-1:0] IDX_M00 = 3'd0;
   localparam logic [IDX_W-1:0] IDX_M01 = 3'd1;
   localparam logic [IDX_W-1:0] IDX_M02 = 3'd2;
   localparam logic [IDX_W-1:0] IDX_M10 = 3'd3;
   localparam logic [IDX_W-1:0] IDX_M11 = 3'd4;
   localparam logic [IDX_W-1:0] IDX_M12 = 3'd5;
   localparam logic [IDX_W-1:0] IDX_M20 = 3'd6;
   localparam logic [IDX_W-1:0] IDX_M21 = 3'd7;

   typedef logic signed [COEF_W-1:0] coef_type;

   typedef struct packed {
      coef_type m00, m01, m02, m10, m11, m12, m20, m21;
   } matrix_type;

   // one quotient lane in flight through the divider
   typedef struct packed {
      logic [MAG_W-1:0]   rem;
      logic [Q_W:0]       quo;   // one extra bit marks overflow past 1023
      logic               neg;
      logic               big;   // quotient surely >= 2^(Q_W+1)
   } lane_type;

   typedef struct packed {
      lane_type          x;
      lane_type          y;
      logic [MAG_W-1:0]  den;
      logic              zero;
   } div_type;
endpackage
`default_nettype wire

// File: sv/perspective_coordinate_mapper.sv
`timescale 1ns / 1ps
`default_nettype none
// Perspective coordinate mapper: maps pixel (col,row) through a 3x3
// projective matrix and returns the clamped integer target pixel.
// Input req_ word: tdata[9:0] pixel_col, [19:10] pixel_row.
// Output rsp_ word: tdata[9:0] mapped_col, [19:10] mapped_row; tuser is
// zero_divisor (divisor w was zero, coordinates forced to 0).
// csr_: write csr_we with csr_index 0..7 (m00 m01 m02 m10 m11 m12 m20 m21),
// 40-bit signed Q15.24 data; other indexes are ignored. Write only while idle.
// Throughput: one word per cycle while the output is not stalled. A word passes
// through two multiply/sum stages, one sign/magnitude stage, eleven
// restoring-divider stages and one clamp/output register before rsp_tvalid
// rises. The divider length, one quotient bit per stage, sets the latency.
// The whole pipeline advances as one; when rsp_tready is low with a word
// waiting, everything holds and req_tready drops; nothing is lost.
// Reset: pipeline empties, matrix returns to identity.
module perspective_coordinate_mapper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // pixel_col, pixel_row, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // mapped_col, mapped_row, zero pad
   output logic             rsp_tuser,  // zero_divisor
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [39:0] csr_data
);
   import pcm_pkg::*;

   matrix_type mat_ff;
   logic advance, mv, dv;
   logic signed [SUM_W-1:0] xn, yn, w;
   logic [PIX_W-1:0] col, row;
   logic zero;

   // a stage may move when the last slot is empty or being drained
   assign advance = !dv || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= '{m00: ONE_COEF, m11: ONE_COEF, default: '0};
      end else if (csr_we) begin
         unique case (csr_index)
            IDX_M00: mat_ff.m00 <= csr_data;
            IDX_M01: mat_ff.m01 <= csr_data;
            IDX_M02: mat_ff.m02 <= csr_data;
            IDX_M10: mat_ff.m10 <= csr_data;
            IDX_M11: mat_ff.m11 <= csr_data;
            IDX_M12: mat_ff.m12 <= csr_data;
            IDX_M20: mat_ff.m20 <= csr_data;
            IDX_M21: mat_ff.m21 <= csr_data;
            default: ;
         endcase
      end
   end

   pcm_mac u_mac (
      .clock, .reset, .advance,
      .in_valid (req_tvalid),
      .in_col   (req_tdata[9:0]),
      .in_row   (req_tdata[19:10]),
      .mat      (mat_ff),
      .out_valid(mv), .out_xn(xn), .out_yn(yn), .out_w(w)
   );

   pcm_div u_div (
      .clock, .reset, .advance,
      .in_valid(mv), .in_xn(xn), .in_yn(yn), .in_w(w),
      .out_valid(dv), .out_col(col), .out_row(row), .out_zero(zero)
   );

   assign rsp_tvalid = dv;
   assign rsp_tdata = {4'b0, row, col};
   assign rsp_tuser = zero;

`ifndef NO_ASSERTIONS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("accept while output blocked");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:20] == 4'b0))
      else $error("pad bits set");
`endif
endmodule
`default_nettype wire

// File: sv/pcm_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// Products (stage 1) then sums (stage 2) for the three projective terms.
module pcm_mac (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  wire logic [pcm_pkg::PIX_W-1:0] in_col,
   input  wire logic [pcm_pkg::PIX_W-1:0] in_row,
   input  wire pcm_pkg::matrix_type       mat,
   output logic                           out_valid,
   output logic signed [pcm_pkg::SUM_W-1:0] out_xn,
   output logic signed [pcm_pkg::SUM_W-1:0] out_yn,
   output logic signed [pcm_pkg::SUM_W-1:0] out_w
);
   import pcm_pkg::*;

   logic signed [SUM_W-1:0] p_ff [6];
   logic signed [SUM_W-1:0] p_in [6];
   logic signed [SUM_W-1:0] xo_ff, yo_ff;
   logic v1_ff, v2_ff;
   logic signed [SUM_W-1:0] xn_ff, yn_ff, w_ff;
   logic signed [PIX_W:0] c_s, r_s;

   always_comb begin
      c_s = signed'({1'b0, in_col});
      r_s = signed'({1'b0, in_row});
      p_in[0] = SUM_W'(mat.m00 * c_s);
      p_in[1] = SUM_W'(mat.m01 * r_s);
      p_in[2] = SUM_W'(mat.m10 * c_s);
      p_in[3] = SUM_W'(mat.m11 * r_s);
      p_in[4] = SUM_W'(mat.m20 * c_s);
      p_in[5] = SUM_W'(mat.m21 * r_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         p_ff  <= p_in;
         xo_ff <= SUM_W'(mat.m02);
         yo_ff <= SUM_W'(mat.m12);
         xn_ff <= p_ff[0] + p_ff[1] + xo_ff;
         yn_ff <= p_ff[2] + p_ff[3] + yo_ff;
         w_ff  <= p_ff[4] + p_ff[5] + signed'(Q_ONE);
      end
   end

   assign out_valid = v2_ff;
   assign out_xn = xn_ff;
   assign out_yn = yn_ff;
   assign out_w = w_ff;
endmodule
`default_nettype wire

// File: sv/pcm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage, both lanes sharing a divisor.
// Only Q_W+1 quotient bits are developed; anything larger saturates.
module pcm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic signed [pcm_pkg::SUM_W-1:0] in_xn,
   input  wire logic signed [pcm_pkg::SUM_W-1:0] in_yn,
   input  wire logic signed [pcm_pkg::SUM_W-1:0] in_w,
   output logic                               out_valid,
   output logic [pcm_pkg::PIX_W-1:0]          out_col,
   output logic [pcm_pkg::PIX_W-1:0]          out_row,
   output logic                               out_zero
);
   import pcm_pkg::*;
   localparam int NSTG = Q_W + 1;

   div_type st_ff [NSTG+1];
   div_type st_in [NSTG+1];
   logic    v_ff  [NSTG+1];
   logic [PIX_W-1:0] col_ff, row_ff;
   logic zero_ff, vo_ff;

   function automatic lane_type lane_init(input logic signed [SUM_W-1:0] n,
                                          input logic signed [SUM_W-1:0] d,
                                          input logic [MAG_W-1:0] ad);
      lane_type l;
      logic [SUM_W-1:0] an;
      an = n[SUM_W-1] ? SUM_W'(-n) : SUM_W'(n);
      l.rem = an[MAG_W-1:0];
      l.quo = '0;
      l.neg = (n[SUM_W-1] != d[SUM_W-1]) && (n != '0);
      // high part of numerator vs divisor: quotient >= 2^NSTG
      l.big = (an[MAG_W-1:0] >> NSTG) >= ad;
      return l;
   endfunction

   function automatic lane_type lane_step(input lane_type l,
                                          input logic [MAG_W-1:0] ad, input int k);
      lane_type o;
      logic [MAG_W+NSTG-1:0] sh;
      o = l;
      sh = (MAG_W+NSTG)'(ad) << k;
      if ((MAG_W+NSTG)'(l.rem) >= sh) begin
         o.rem = l.rem - MAG_W'(sh);
         o.quo[k] = 1'b1;
      end
      return o;
   endfunction

   function automatic logic [PIX_W-1:0] clampq(input lane_type l, input int lim);
      logic [PIX_W-1:0] r;
      if (l.neg || l.quo == '0) r = '0;
      else if (l.big || 32'(l.quo) > lim - 1) r = PIX_W'(lim - 1);
      else r = PIX_W'(l.quo);
      return r;
   endfunction

   always_comb begin
      logic [SUM_W-1:0] aw;
      aw = in_w[SUM_W-1] ? SUM_W'(-in_w) : SUM_W'(in_w);
      st_in[0].den  = aw[MAG_W-1:0];
      st_in[0].zero = (in_w == '0);
      st_in[0].x = lane_init(in_xn, in_w, aw[MAG_W-1:0]);
      st_in[0].y = lane_init(in_yn, in_w, aw[MAG_W-1:0]);
      for (int s = 1; s <= NSTG; s++) begin
         st_in[s] = st_ff[s-1];
         st_in[s].x = lane_step(st_ff[s-1].x, st_ff[s-1].den, NSTG - s);
         st_in[s].y = lane_step(st_ff[s-1].y, st_ff[s-1].den, NSTG - s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NSTG; s++) v_ff[s] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s <= NSTG; s++) v_ff[s] <= v_ff[s-1];
         vo_ff <= v_ff[NSTG];
      end
      if (advance) begin
         st_ff <= st_in;
         zero_ff <= st_ff[NSTG].zero;
         col_ff <= st_ff[NSTG].zero ? '0 : clampq(st_ff[NSTG].x, IMAGE_COLS);
         row_ff <= st_ff[NSTG].zero ? '0 : clampq(st_ff[NSTG].y, IMAGE_ROWS);
      end
   end

   assign out_valid = vo_ff;
   assign out_col = col_ff;
   assign out_row = row_ff;
   assign out_zero = zero_ff;

`ifndef NO_ASSERTIONS
   a_zero_clear: assert property (@(posedge clock) disable iff (reset)
      (vo_ff && zero_ff) |-> (col_ff == '0 && row_ff == '0))
      else $error("zero divisor with nonzero coordinate");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> (32'(col_ff) < IMAGE_COLS && 32'(row_ff) < IMAGE_ROWS))
      else $error("coordinate beyond image");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (vo_ff == $past(vo_ff)))
      else $error("valid moved during stall");
`endif
endmodule
`default_nettype wire
